FILE: design/csu_pkg.sv
// Shared types, widths and constants of the cosine similarity unit.
package csu_pkg;

  localparam int unsigned MAX_LENGTH = 4096;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned PRD_W  = 2 * IN_W;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned CNT_W  = $clog2(MAX_LENGTH + 2);

  localparam int unsigned MUL_PARTS = 2;
  localparam int unsigned HALF_W    = SUM_W / MUL_PARTS;
  localparam int unsigned MUL_STEPS = MUL_PARTS * MUL_PARTS;
  localparam int unsigned MIDX_W    = 2 * $clog2(MUL_PARTS);
  localparam int unsigned PROD_W    = 2 * SUM_W;

  localparam int unsigned FRAC     = 14;
  localparam int unsigned Q_W      = FRAC + 1;
  localparam int unsigned SIM_W    = 16;
  localparam int unsigned T_SHIFT  = 2 * FRAC;
  localparam int unsigned PS_SHIFT = 2 * (Q_W - 1);
  localparam int unsigned SRCH_W   = PROD_W + 2 * Q_W + 1;
  localparam int unsigned SEQ_W    = $clog2(Q_W + 1);

  typedef struct packed {
    logic signed [IN_W-1:0] a_value;
    logic signed [IN_W-1:0] b_value;
    logic                   last;
  } in_item_t;

  typedef struct packed {
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;
    logic                    length_overflow;
  } out_item_t;

  typedef struct packed {
    logic              take;
    logic              acc_clear;
    logic              mul_clear;
    logic              mul_issue;
    logic              mul_add;
    logic              mul_sel_r;
    logic [MIDX_W-1:0] mul_idx;
    logic              p_load;
    logic              srch_init;
    logic              srch_add;
    logic              srch_cmp;
    logic              out_load;
  } cmd_t;

endpackage

FILE: design/csu_ctrl.sv
// Controller state machine of the cosine similarity unit.
module csu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output csu_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_ACC,
    S_DRAIN,
    S_MUL_P,
    S_MUL_R,
    S_INIT,
    S_ADD,
    S_CMP,
    S_DONE
  } state_e;

  localparam logic [csu_pkg::SEQ_W-1:0] MUL_LAST = csu_pkg::SEQ_W'(csu_pkg::MUL_STEPS);
  localparam logic [csu_pkg::SEQ_W-1:0] BIT_LAST = csu_pkg::SEQ_W'(csu_pkg::Q_W - 1);

  state_e                      state_q, state_d;
  logic [csu_pkg::SEQ_W-1:0]   cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic                        accept;
  logic                        mul_state;

  assign in_ready_o  = (state_q == S_ACC);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign mul_state   = (state_q == S_MUL_P) || (state_q == S_MUL_R);

  always_comb begin
    cmd_o           = '0;
    cmd_o.take      = accept;
    cmd_o.mul_clear = mul_state && (cnt_q == '0);
    cmd_o.mul_issue = mul_state && (cnt_q < MUL_LAST);
    cmd_o.mul_add   = mul_state && (cnt_q != '0);
    cmd_o.mul_sel_r = (state_q == S_MUL_R);
    cmd_o.mul_idx   = cnt_q[csu_pkg::MIDX_W-1:0];
    cmd_o.p_load    = (state_q == S_MUL_R) && (cnt_q == '0);
    cmd_o.srch_init = (state_q == S_INIT);
    cmd_o.acc_clear = (state_q == S_INIT);
    cmd_o.srch_add  = (state_q == S_ADD);
    cmd_o.srch_cmp  = (state_q == S_CMP);
    cmd_o.out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_ACC: begin
        if (accept && in_last_i) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cnt_d   = '0;
        state_d = S_MUL_P;
      end
      S_MUL_P: begin
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          state_d = S_MUL_R;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MUL_R: begin
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          state_d = S_INIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_INIT: begin
        state_d = S_ADD;
      end
      S_ADD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (cnt_q == BIT_LAST) begin
          state_d = S_DONE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_ADD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_drain_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_last_i) |=> !in_ready_o)
    else $error("item taken before drain");

  a_init_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.srch_init |-> $past(state_q == S_MUL_R))
    else $error("search started before products ready");
`endif

endmodule

FILE: design/csu_datapath.sv
// Datapath of the cosine similarity unit: accumulators, shared multiplier, root search.
module csu_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csu_pkg::cmd_t         cmd_i,
  input  csu_pkg::in_item_t     in_item_i,
  output csu_pkg::out_item_t    out_item_o
);

  localparam logic [csu_pkg::CNT_W-1:0] CNT_MAX = csu_pkg::CNT_W'(csu_pkg::MAX_LENGTH);
  localparam logic [csu_pkg::Q_W-1:0]   Q_ONE   = csu_pkg::Q_W'(1 << csu_pkg::FRAC);
  localparam logic [csu_pkg::Q_W-1:0]   Q_TOP   = csu_pkg::Q_W'(1 << (csu_pkg::Q_W - 1));

  // per-item products
  logic signed [csu_pkg::PRD_W-1:0] prod_ab_q;
  logic        [csu_pkg::PRD_W-1:0] sq_a_q, sq_b_q;
  logic                             prod_vld_q, prod_en_q;
  logic signed [csu_pkg::PRD_W-1:0] prod_ab_d, sq_a_s, sq_b_s;

  // accumulators
  logic signed [csu_pkg::SUM_W-1:0] dot_q;
  logic        [csu_pkg::SUM_W-1:0] sqa_q, sqb_q;
  logic        [csu_pkg::CNT_W-1:0] cnt_q;

  // shared multiplier
  logic [csu_pkg::SUM_W-1:0]    mag, x_op, y_op;
  logic [csu_pkg::HALF_W-1:0]   x_part, y_part;
  logic [2*csu_pkg::HALF_W-1:0] pp_q;
  logic [csu_pkg::MIDX_W-1:0]   pp_idx_q;
  logic [1:0]                   idx_sum;
  logic [csu_pkg::PROD_W-1:0]   pp_sh, mul_acc_q, p_q;

  // root search
  logic [csu_pkg::SRCH_W-1:0] y_q, zs_q, ps_q, t_q, trial_q;
  logic [csu_pkg::Q_W-1:0]    q_q, qbit_q, q_sat;
  logic                       zero_q, ovf_q, neg_q;
  logic [csu_pkg::SIM_W-1:0]  q_ext;

  csu_pkg::out_item_t out_item_q;

  assign prod_ab_d = in_item_i.a_value * in_item_i.b_value;
  assign sq_a_s    = in_item_i.a_value * in_item_i.a_value;
  assign sq_b_s    = in_item_i.b_value * in_item_i.b_value;

  assign mag    = dot_q[csu_pkg::SUM_W-1] ? csu_pkg::SUM_W'(-dot_q) : csu_pkg::SUM_W'(dot_q);
  assign x_op   = cmd_i.mul_sel_r ? mag : sqa_q;
  assign y_op   = cmd_i.mul_sel_r ? mag : sqb_q;
  assign x_part = x_op[cmd_i.mul_idx[1]*csu_pkg::HALF_W +: csu_pkg::HALF_W];
  assign y_part = y_op[cmd_i.mul_idx[0]*csu_pkg::HALF_W +: csu_pkg::HALF_W];

  assign idx_sum = {1'b0, pp_idx_q[1]} + {1'b0, pp_idx_q[0]};
  assign pp_sh   = csu_pkg::PROD_W'(pp_q) << (csu_pkg::HALF_W * idx_sum);

  assign q_sat = (q_q > Q_ONE) ? Q_ONE : q_q;
  assign q_ext = csu_pkg::SIM_W'(q_sat);

  assign out_item_o = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_en_q  <= 1'b0;
      dot_q      <= '0;
      sqa_q      <= '0;
      sqb_q      <= '0;
      cnt_q      <= '0;
    end else begin
      prod_vld_q <= cmd_i.take;
      prod_en_q  <= cmd_i.take && (cnt_q < CNT_MAX);
      if (cmd_i.acc_clear) begin
        dot_q <= '0;
        sqa_q <= '0;
        sqb_q <= '0;
        cnt_q <= '0;
      end else begin
        if (prod_vld_q && prod_en_q) begin
          dot_q <= dot_q + {{(csu_pkg::SUM_W-csu_pkg::PRD_W){prod_ab_q[csu_pkg::PRD_W-1]}},
                            prod_ab_q};
          sqa_q <= sqa_q + csu_pkg::SUM_W'(sq_a_q);
          sqb_q <= sqb_q + csu_pkg::SUM_W'(sq_b_q);
        end
        if (cmd_i.take && (cnt_q <= CNT_MAX)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      prod_ab_q <= prod_ab_d;
      sq_a_q    <= $unsigned(sq_a_s);
      sq_b_q    <= $unsigned(sq_b_s);
    end
    if (cmd_i.mul_issue) begin
      pp_q     <= x_part * y_part;
      pp_idx_q <= cmd_i.mul_idx;
    end
    if (cmd_i.mul_clear) begin
      mul_acc_q <= '0;
    end else if (cmd_i.mul_add) begin
      mul_acc_q <= mul_acc_q + pp_sh;
    end
    if (cmd_i.p_load) begin
      p_q <= mul_acc_q;
    end
    if (cmd_i.srch_init) begin
      y_q    <= '0;
      zs_q   <= '0;
      ps_q   <= csu_pkg::SRCH_W'(p_q) << csu_pkg::PS_SHIFT;
      t_q    <= csu_pkg::SRCH_W'(mul_acc_q) << csu_pkg::T_SHIFT;
      q_q    <= '0;
      qbit_q <= Q_TOP;
      zero_q <= (sqa_q == '0) || (sqb_q == '0);
      ovf_q  <= (cnt_q > CNT_MAX);
      neg_q  <= dot_q[csu_pkg::SUM_W-1];
    end
    if (cmd_i.srch_add) begin
      trial_q <= y_q + zs_q + ps_q;
    end
    if (cmd_i.srch_cmp) begin
      if (trial_q <= t_q) begin
        y_q  <= trial_q;
        zs_q <= (zs_q >> 1) + ps_q;
        q_q  <= q_q | qbit_q;
      end else begin
        zs_q <= zs_q >> 1;
      end
      ps_q   <= ps_q >> 2;
      qbit_q <= qbit_q >> 1;
    end
    if (cmd_i.out_load) begin
      out_item_q.similarity      <= zero_q ? '0 : (neg_q ? -q_ext : q_ext);
      out_item_q.zero_norm       <= zero_q;
      out_item_q.length_overflow <= ovf_q;
    end
  end

`ifndef SYNTH
  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.srch_cmp |=> (y_q <= t_q))
    else $error("root search overshoot");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX + 1'b1)
    else $error("element count beyond saturation");

  a_bit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.srch_add |-> $onehot(qbit_q))
    else $error("trial bit lost");
`endif

endmodule

FILE: design/cosine_similarity_unit_top.sv
// Top level of the cosine similarity unit.
// Input channel (in_valid_i, in_ready_o, in_item_i) takes one element pair per item;
// an item with last set closes the vector pair. Output channel (out_valid_o,
// out_ready_i, out_item_o) gives one result item per closed vector pair.
// While a vector streams, one item is taken every cycle. The item with last set
// is followed by a stretch with ready low: a drain state, two passes on the
// shared 24x24 multiplier (norm product, squared dot), a setup state, an add
// and a compare step for each of 15 root-search bits and a load state.
// The result lands in an output register; the next vector may stream in while
// it waits. If the receiver stalls, the following result holds back in the
// controller until the register frees, and ready stays low meanwhile.
// Pairs past the length limit are counted but not summed and the result is
// flagged. Reset clears the accumulators, the count and out_valid_o and leaves
// the unit ready for the first element of a vector.
module cosine_similarity_unit_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  csu_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output csu_pkg::out_item_t  out_item_o
);

  csu_pkg::cmd_t cmd;

  csu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_item_i.last),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  csu_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the cosine similarity unit: vector pairs in, Q1.14 results out.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ONE_Q14        = 1 << csu_pkg::FRAC;
  localparam int          CALC_LATENCY   = 60;
  localparam int          RECV_HOLD      = 300;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          PHASE_ITEMS    = 120;

  typedef enum int {
    VEC_RANDOM, VEC_SMALL, VEC_EXTREME, VEC_SAME, VEC_NEGATED, VEC_ZERO_A, VEC_ZERO_B
  } vec_kind_e;

  class cosine_scoreboard;
    logic signed [csu_pkg::SUM_W-1:0] dot_acc;
    logic [csu_pkg::SUM_W-1:0]        norm_a;
    logic [csu_pkg::SUM_W-1:0]        norm_b;
    int                               pair_count;
    csu_pkg::out_item_t               pending_results[$];
    int                               errors;

    function new();
      dot_acc    = '0;
      norm_a     = '0;
      norm_b     = '0;
      pair_count = 0;
      errors     = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void flag(string what, int expv, int actv);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, what, expv, actv);
    endfunction

    // largest q up to 2^14 with q^2 * na * nb <= mag^2 * 2^28
    function logic [csu_pkg::FRAC:0] q14_magnitude(logic [csu_pkg::SUM_W-1:0] mag,
                                                   logic [csu_pkg::SUM_W-1:0] na,
                                                   logic [csu_pkg::SUM_W-1:0] nb);
      logic [159:0] bound;
      logic [159:0] lhs;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      lo = 0;
      hi = ONE_Q14;
      bound = 160'(mag);
      bound = (bound * bound) << csu_pkg::T_SHIFT;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 160'(mid);
        lhs = lhs * lhs;
        lhs = lhs * na;
        lhs = lhs * nb;
        if (lhs <= bound) lo = mid;
        else hi = mid - 1;
      end
      return lo[csu_pkg::FRAC:0];
    endfunction

    function void note_pair(csu_pkg::in_item_t it);
      int                        pa;
      int                        pb;
      int                        prod;
      logic [31:0]               sq;
      logic [csu_pkg::SUM_W-1:0] mag;
      logic [csu_pkg::SIM_W-1:0] sim;
      csu_pkg::out_item_t        r;
      pa = int'(it.a_value);
      pb = int'(it.b_value);
      if (pair_count < csu_pkg::MAX_LENGTH) begin
        prod = pa * pb;
        dot_acc = dot_acc + prod;
        sq = pa * pa;
        norm_a = norm_a + sq;
        sq = pb * pb;
        norm_b = norm_b + sq;
      end
      if (pair_count <= csu_pkg::MAX_LENGTH) pair_count++;
      if (!it.last) return;
      r.length_overflow = (pair_count > csu_pkg::MAX_LENGTH);
      if (norm_a == 0 || norm_b == 0) begin
        r.zero_norm  = 1'b1;
        r.similarity = '0;
      end else begin
        r.zero_norm = 1'b0;
        mag = (dot_acc < 0) ? -dot_acc : dot_acc;
        sim = {1'b0, q14_magnitude(mag, norm_a, norm_b)};
        if (dot_acc < 0) sim = -sim;
        r.similarity = sim;
      end
      pending_results.push_back(r);
      dot_acc    = '0;
      norm_a     = '0;
      norm_b     = '0;
      pair_count = 0;
    endfunction

    function void check_result(csu_pkg::out_item_t got);
      csu_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        flag("unexpected result, similarity", 0, int'($signed(got.similarity)));
        return;
      end
      want = pending_results.pop_front();
      if (got.similarity !== want.similarity) begin
        flag("similarity", int'($signed(want.similarity)), int'($signed(got.similarity)));
      end
      if (got.zero_norm !== want.zero_norm) begin
        flag("zero_norm", int'(want.zero_norm), int'(got.zero_norm));
      end
      if (got.length_overflow !== want.length_overflow) begin
        flag("length_overflow", int'(want.length_overflow), int'(got.length_overflow));
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  csu_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  csu_pkg::out_item_t out_item_o;

  cosine_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_request;
  int  quiet_cycles;

  cosine_similarity_unit_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) sb.note_pair(in_item_i);
    if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (RECV_HOLD) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic csu_pkg::in_item_t pair(logic signed [csu_pkg::IN_W-1:0] a,
                                             logic signed [csu_pkg::IN_W-1:0] b,
                                             logic last);
    csu_pkg::in_item_t it;
    it.a_value = a;
    it.b_value = b;
    it.last    = last;
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_pair(csu_pkg::in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_vector(int len, vec_kind_e kind);
    logic signed [csu_pkg::IN_W-1:0] a;
    logic signed [csu_pkg::IN_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      a = csu_pkg::IN_W'($urandom);
      b = csu_pkg::IN_W'($urandom);
      unique case (kind)
        VEC_SMALL: begin
          a = csu_pkg::IN_W'($urandom_range(14));
          a = a - 16'sd7;
          b = csu_pkg::IN_W'($urandom_range(14));
          b = b - 16'sd7;
        end
        VEC_EXTREME: begin
          a = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
          b = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
        end
        VEC_SAME:    b = a;
        VEC_NEGATED: begin
          if (a == 16'sh8000) a = 16'sh8001;
          b = -a;
        end
        VEC_ZERO_A:  a = '0;
        VEC_ZERO_B:  b = '0;
        default: ;
      endcase
      send_pair(pair(a, b, i == len - 1));
    end
  endtask

  task automatic stream_random(int target);
    int        sent;
    int        len;
    int        pick;
    vec_kind_e kind;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 55) len = $urandom_range(4, 1);
      else if (pick < 90) len = $urandom_range(16, 5);
      else len = $urandom_range(60, 17);
      pick = $urandom_range(99);
      if (pick < 40) kind = VEC_RANDOM;
      else if (pick < 60) kind = VEC_SMALL;
      else if (pick < 70) kind = VEC_EXTREME;
      else if (pick < 78) kind = VEC_SAME;
      else if (pick < 86) kind = VEC_NEGATED;
      else if (pick < 93) kind = VEC_ZERO_A;
      else kind = VEC_ZERO_B;
      send_vector(len, kind);
      sent += len;
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (CALC_LATENCY) @(negedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    hold_request  = 1'b0;
    quiet_cycles  = 0;
    send_idle_pct = 16;
    recv_idle_pct = 78;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_pair(pair(16'sh8000, 16'sh8000, 1'b1));
    send_pair(pair(16'sh8000, 16'sh7fff, 1'b1));
    send_pair(pair(16'sh7fff, 16'sh7fff, 1'b1));
    send_pair(pair(16'sd0, 16'sd0, 1'b1));
    send_pair(pair(16'sd0, 16'sh8000, 1'b1));
    send_pair(pair(16'sd12345, 16'sd0, 1'b1));
    send_pair(pair(16'sd1, 16'sd0, 1'b0));
    send_pair(pair(16'sd0, 16'sd1, 1'b1));
    send_pair(pair(16'sd3, 16'sd4, 1'b0));
    send_pair(pair(16'sd4, 16'sd3, 1'b1));
    send_pair(pair(16'sd1, 16'sd1, 1'b0));
    send_pair(pair(16'sd1, -16'sd1, 1'b0));
    send_pair(pair(-16'sd1, 16'sd1, 1'b1));
    send_pair(pair(16'sd0, 16'sd0, 1'b0));
    send_pair(pair(16'sd5, 16'sd0, 1'b0));
    send_pair(pair(16'sd0, 16'sd7, 1'b1));
    send_pair(pair(16'sh7fff, 16'sh8000, 1'b0));
    send_pair(pair(16'sh8000, 16'sh7fff, 1'b1));
    send_pair(pair(16'sh8000, 16'sh8000, 1'b0));
    send_pair(pair(16'sh7fff, 16'sh7fff, 1'b0));
    send_pair(pair(-16'sd1, 16'sd1, 1'b1));
    stream_random(PHASE_ITEMS);
    drain_results();

    send_idle_pct = 78;
    recv_idle_pct = 16;
    stream_random(PHASE_ITEMS);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    repeat (30) send_vector($urandom_range(3, 1), VEC_RANDOM);
    drain_results();
    stream_random(PHASE_ITEMS);
    drain_results();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/csu_pkg.sv
design/csu_ctrl.sv
design/csu_datapath.sv
design/cosine_similarity_unit_top.sv
bench/testbench.sv
